[hdl/rcl_pkg.sv]
// Shared constants, types and codes for the raster component labeler.
`default_nettype none
package rcl_pkg;

    localparam int LABEL_BITS    = 8;
    localparam int NLABELS       = 1 << LABEL_BITS;
    localparam int REACH         = 5;
    localparam int NB_MAX        = 2 * REACH + 1;
    localparam int NB_BITS       = $clog2(NB_MAX + 1);
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int ROW_ADDR_MAX  = 12;
    localparam int CFG_BITS      = 11;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(640);

    // register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    // request types
    localparam logic REQ_LABEL   = 1'b0;
    localparam logic REQ_RESOLVE = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_START,
        S_GATH,
        S_DECIDE,
        S_UNEXT,
        S_FRD,
        S_FCHK,
        S_WRITE,
        S_COPY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    // command to the row store
    typedef struct packed {
        logic                    rd_en;
        logic [ROW_ADDR_MAX-1:0] rd_addr;
        logic                    wr_cur;
        logic                    wr_prev;
        logic [ROW_ADDR_MAX-1:0] wr_addr;
        logic [LABEL_BITS-1:0]   cur_data;
        logic [LABEL_BITS-1:0]   prev_data;
    } t_row_cmd;

endpackage
`default_nettype wire

[hdl/raster_component_labeler.sv]
// Top level of the raster component labeler: request sequencer, parent table, row store.
`default_nettype none
// Labels raster-order pixels (first pass of two-pass connected-component labeling)
// and resolves provisional labels to their roots (second pass). One request is
// worked at a time. A foreground pixel reads its 2 or 11 neighbors and picks a
// label. When a neighbor is labeled it also scans the neighbors for unions, with
// two parent chain walks per union on the single parent-table port. The last
// pixel of a row adds a copy of the current row into the previous row. A resolve
// walks the parent chain of its query label to the root. After reset, and on
// every frame start, a clearing pass zeroes the row store and parent table; no
// request is taken during it.
module raster_component_labeler #(
    parameter int MAX_WIDTH = rcl_pkg::MAX_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire [rcl_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_req_type,
    input  wire [7:0]                        i_pixel_value,
    input  wire [7:0]                        i_query_label,
    input  wire                              i_frame_start,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [7:0]                       o_label_out,
    output logic                             o_label_overflow
);
    localparam int LB      = rcl_pkg::LABEL_BITS;
    localparam int NL      = rcl_pkg::NLABELS;
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CLR_LEN = (MAX_WIDTH > NL) ? MAX_WIDTH : NL;
    localparam int CW      = $clog2(CLR_LEN + 1);
    localparam int NBB     = rcl_pkg::NB_BITS;
    localparam int NBM     = rcl_pkg::NB_MAX;
    localparam int PW      = AW + 2;

    // configuration
    logic                          r_mode;
    logic [rcl_pkg::CFG_BITS-1:0]  r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_width <= rcl_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcl_pkg::REG_MODE:  r_mode  <= i_cfg_data[0];
                rcl_pkg::REG_WIDTH: r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective width, clamped to 1..MAX_WIDTH
    logic [31:0] w_full;
    logic [AW:0] w_eff;
    always_comb begin
        if (r_width == '0) begin
            w_full = 32'd1;
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(r_width);
        end
        w_eff = w_full[AW:0];
    end

    // state
    rcl_pkg::t_state r_state, n_state;
    rcl_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]   r_clr, n_clr;
    logic            r_after_clr, n_after_clr;
    logic [7:0]      r_pix, n_pix;
    logic [LB:0]     r_fresh, n_fresh;
    logic [AW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_x, n_x;
    logic            r_first, n_first;
    logic            r_ovf, n_ovf;
    logic [NBB-1:0]  r_k, n_k;
    logic            r_cap, n_cap;
    logic [NBB-1:0]  r_cap_k, n_cap_k;
    logic            r_cap_ok, n_cap_ok;
    logic            r_cap_cur, n_cap_cur;
    logic [LB-1:0]   r_nb [NBM];
    logic [LB-1:0]   n_nb [NBM];
    logic [LB-1:0]   r_best, n_best;
    logic [LB-1:0]   r_label, n_label;
    logic [NBB-1:0]  r_i, n_i;
    logic [LB-1:0]   r_j, n_j;
    logic [LB-1:0]   r_a, n_a;
    logic [AW:0]     r_cp, n_cp;
    logic            r_cp_pend, n_cp_pend;
    logic [AW-1:0]   r_cp_a, n_cp_a;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_label, n_out_label;
    logic            r_out_ovf, n_out_ovf;

    // parent table
    logic [LB-1:0] par_mem [NL];
    logic [LB-1:0] par_rdata;
    logic          par_re, par_we;
    logic [LB-1:0] par_raddr, par_waddr, par_wdata;

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (par_re) begin
            par_rdata <= par_mem[par_raddr];
        end
    end

    // row store
    rcl_pkg::t_row_cmd row_cmd;
    logic [2*LB-1:0]   row_rdata;

    rcl_row_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row (
        .i_clk   (i_clk),
        .i_cmd   (row_cmd),
        .o_rdata (row_rdata)
    );

    logic [NBB-1:0] nb_cnt;
    assign nb_cnt = r_mode ? NBB'(NBM) : NBB'(2);

    // sequencer
    logic [PW-1:0] pos;
    logic [LB-1:0] cap_v;
    logic [LB-1:0] nb_i;
    logic          out_free;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_after_clr = r_after_clr;
        n_pix       = r_pix;
        n_fresh     = r_fresh;
        n_col       = r_col;
        n_x         = r_x;
        n_first     = r_first;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_cap       = r_cap;
        n_cap_k     = r_cap_k;
        n_cap_ok    = r_cap_ok;
        n_cap_cur   = r_cap_cur;
        n_nb        = r_nb;
        n_best      = r_best;
        n_label     = r_label;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_cp        = r_cp;
        n_cp_pend   = r_cp_pend;
        n_cp_a      = r_cp_a;
        n_out_label = r_out_label;
        n_out_ovf   = r_out_ovf;
        out_free    = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;

        par_re    = 1'b0;
        par_we    = 1'b0;
        par_raddr = r_j;
        par_waddr = r_j;
        par_wdata = r_a;
        row_cmd   = '0;
        pos       = '0;
        cap_v     = '0;
        nb_i      = r_nb[r_i[NBB-1:0] < NBB'(NBM) ? r_i : '0];
        o_in_stall = (r_state != rcl_pkg::S_IDLE);

        unique case (r_state)
            // zero row store and parent table, restart frame counters
            rcl_pkg::S_CLR: begin
                if (r_clr < CW'(MAX_WIDTH)) begin
                    row_cmd.wr_cur  = 1'b1;
                    row_cmd.wr_prev = 1'b1;
                    row_cmd.wr_addr = rcl_pkg::ROW_ADDR_MAX'(r_clr);
                end
                if (r_clr < CW'(NL)) begin
                    par_we    = 1'b1;
                    par_waddr = r_clr[LB-1:0];
                    par_wdata = '0;
                end
                n_fresh = (LB+1)'(1);
                n_col   = '0;
                n_first = 1'b1;
                n_ovf   = 1'b0;
                if (r_clr == CW'(CLR_LEN - 1)) begin
                    n_clr   = '0;
                    n_state = r_after_clr ? rcl_pkg::S_START : rcl_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
            end

            rcl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_pix = i_pixel_value;
                    if (i_req_type == rcl_pkg::REQ_RESOLVE) begin
                        n_j     = i_query_label[LB-1:0];
                        n_phase = rcl_pkg::PH_R;
                        n_state = rcl_pkg::S_FRD;
                    end else if (i_frame_start) begin
                        n_after_clr = 1'b1;
                        n_clr       = '0;
                        n_state     = rcl_pkg::S_CLR;
                    end else begin
                        n_state = rcl_pkg::S_START;
                    end
                end
            end

            // clamp column, start neighbor gather
            rcl_pkg::S_START: begin
                n_x = ({1'b0, r_col} >= w_eff) ? AW'(w_eff - (AW+1)'(1)) : r_col;
                n_best = '0;
                n_k    = '0;
                n_cap  = 1'b0;
                if (r_pix == '0) begin
                    n_label = '0;
                    n_state = rcl_pkg::S_WRITE;
                end else begin
                    n_state = rcl_pkg::S_GATH;
                end
            end

            // one row-store read per neighbor, running minimum on capture
            rcl_pkg::S_GATH: begin
                if (r_cap) begin
                    if (r_cap_ok) begin
                        cap_v = r_cap_cur ? row_rdata[LB-1:0] : row_rdata[2*LB-1:LB];
                    end
                    n_nb[r_cap_k] = cap_v;
                    if (cap_v != '0 && (r_best == '0 || cap_v < r_best)) begin
                        n_best = cap_v;
                    end
                end
                if (r_k < nb_cnt) begin
                    row_cmd.rd_en = 1'b1;
                    if (r_mode) begin
                        pos = PW'({2'b00, r_x}) + PW'(r_k) - PW'(rcl_pkg::REACH);
                        row_cmd.rd_addr = rcl_pkg::ROW_ADDR_MAX'(pos[AW-1:0]);
                        n_cap_ok  = !r_first && !pos[PW-1] && (pos[AW:0] < w_eff);
                        n_cap_cur = 1'b0;
                    end else if (r_k == '0) begin
                        row_cmd.rd_addr = rcl_pkg::ROW_ADDR_MAX'(r_x);
                        n_cap_ok  = !r_first;
                        n_cap_cur = 1'b0;
                    end else begin
                        row_cmd.rd_addr = rcl_pkg::ROW_ADDR_MAX'(r_x - AW'(1));
                        n_cap_ok  = (r_x != '0);
                        n_cap_cur = 1'b1;
                    end
                    n_cap   = 1'b1;
                    n_cap_k = r_k;
                    n_k     = r_k + NBB'(1);
                end else begin
                    n_cap = 1'b0;
                    if (!r_cap) begin
                        n_state = rcl_pkg::S_DECIDE;
                    end
                end
            end

            // fresh label or minimum neighbor
            rcl_pkg::S_DECIDE: begin
                if (r_best == '0) begin
                    if (r_fresh <= (LB+1)'(NL - 1)) begin
                        n_label = r_fresh[LB-1:0];
                        n_fresh = r_fresh + (LB+1)'(1);
                    end else begin
                        n_label = LB'(NL - 1);
                        n_ovf   = 1'b1;
                    end
                    n_state = rcl_pkg::S_WRITE;
                end else begin
                    n_label = r_best;
                    n_i     = '0;
                    n_state = rcl_pkg::S_UNEXT;
                end
            end

            // pick next neighbor that needs a union
            rcl_pkg::S_UNEXT: begin
                if (r_i == nb_cnt) begin
                    n_state = rcl_pkg::S_WRITE;
                end else if (nb_i != '0 && nb_i != r_label) begin
                    n_j     = r_label;
                    n_phase = rcl_pkg::PH_A;
                    n_state = rcl_pkg::S_FRD;
                end else begin
                    n_i = r_i + NBB'(1);
                end
            end

            rcl_pkg::S_FRD: begin
                par_re    = 1'b1;
                par_raddr = r_j;
                n_state   = rcl_pkg::S_FCHK;
            end

            // chain walk: one parent read a cycle until a root shows up
            rcl_pkg::S_FCHK: begin
                if (par_rdata == '0) begin
                    unique case (r_phase)
                        rcl_pkg::PH_A: begin
                            n_a     = r_j;
                            n_j     = nb_i;
                            n_phase = rcl_pkg::PH_B;
                            n_state = rcl_pkg::S_FRD;
                        end
                        rcl_pkg::PH_B: begin
                            if (r_a != r_j) begin
                                par_we    = 1'b1;
                                par_waddr = r_j;
                                par_wdata = r_a;
                            end
                            n_i     = r_i + NBB'(1);
                            n_state = rcl_pkg::S_UNEXT;
                        end
                        default: begin
                            n_label = r_j;
                            n_state = rcl_pkg::S_DONE;
                        end
                    endcase
                end else begin
                    par_re    = 1'b1;
                    par_raddr = par_rdata;
                    n_j       = par_rdata;
                end
            end

            // store label in current row, advance column
            rcl_pkg::S_WRITE: begin
                row_cmd.wr_cur   = 1'b1;
                row_cmd.wr_addr  = rcl_pkg::ROW_ADDR_MAX'(r_x);
                row_cmd.cur_data = r_label;
                if ({1'b0, r_x} + (AW+1)'(1) >= w_eff) begin
                    n_cp      = '0;
                    n_cp_pend = 1'b0;
                    n_state   = rcl_pkg::S_COPY;
                end else begin
                    n_col   = r_x + AW'(1);
                    n_state = rcl_pkg::S_DONE;
                end
            end

            // copy current row into previous row, read one ahead of write
            rcl_pkg::S_COPY: begin
                if (r_cp_pend) begin
                    row_cmd.wr_prev   = 1'b1;
                    row_cmd.wr_addr   = rcl_pkg::ROW_ADDR_MAX'(r_cp_a);
                    row_cmd.prev_data = row_rdata[LB-1:0];
                end
                if (r_cp < (AW+1)'(MAX_WIDTH)) begin
                    row_cmd.rd_en   = 1'b1;
                    row_cmd.rd_addr = rcl_pkg::ROW_ADDR_MAX'(r_cp[AW-1:0]);
                    n_cp_pend = 1'b1;
                    n_cp_a    = r_cp[AW-1:0];
                    n_cp      = r_cp + (AW+1)'(1);
                end else begin
                    n_cp_pend = 1'b0;
                    if (!r_cp_pend) begin
                        n_first = 1'b0;
                        n_col   = '0;
                        n_state = rcl_pkg::S_DONE;
                    end
                end
            end

            // hand result to output register
            rcl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_label = 8'(r_label);
                    n_out_ovf   = r_ovf;
                    n_after_clr = 1'b0;
                    n_state     = rcl_pkg::S_IDLE;
                end
            end

            default: n_state = rcl_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcl_pkg::S_CLR;
            r_clr       <= '0;
            r_after_clr <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_fresh     <= (LB+1)'(1);
            r_col       <= '0;
            r_first     <= 1'b1;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_after_clr <= n_after_clr;
            r_out_valid <= n_out_valid;
            r_cap       <= n_cap;
            r_cp_pend   <= n_cp_pend;
            r_fresh     <= n_fresh;
            r_col       <= n_col;
            r_first     <= n_first;
            r_ovf       <= n_ovf;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_pix       <= n_pix;
        r_x         <= n_x;
        r_k         <= n_k;
        r_cap_k     <= n_cap_k;
        r_cap_ok    <= n_cap_ok;
        r_cap_cur   <= n_cap_cur;
        r_nb        <= n_nb;
        r_best      <= n_best;
        r_label     <= n_label;
        r_i         <= n_i;
        r_j         <= n_j;
        r_a         <= n_a;
        r_cp        <= n_cp;
        r_cp_a      <= n_cp_a;
        r_out_label <= n_out_label;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid      = r_out_valid;
    assign o_label_out      = r_out_label;
    assign o_label_overflow = r_out_ovf;

`ifndef SYNTHESIS
    // fresh counter never runs past one beyond the largest label
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= (LB+1)'(NL))
        else $error("fresh label counter out of range");

    // overflow only once every fresh label is used
    a_ovf_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_fresh == (LB+1)'(NL)))
        else $error("overflow flag set with fresh labels left");

    // a parent write never targets the entry being read in the same cycle
    a_par_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(par_we && par_re && (par_waddr == par_raddr)))
        else $error("parent table read and write collide");

    // an accepted request always moves the sequencer out of idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != rcl_pkg::S_IDLE))
        else $error("request accepted without starting work");
`endif

endmodule
`default_nettype wire

[hdl/rcl_row_store.sv]
// Row label store: previous and current row labels side by side, per-half write enables.
`default_nettype none
module rcl_row_store #(
    parameter int MAX_WIDTH = rcl_pkg::MAX_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire rcl_pkg::t_row_cmd               i_cmd,
    output logic [2*rcl_pkg::LABEL_BITS-1:0]     o_rdata
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LB = rcl_pkg::LABEL_BITS;

    // entry = {previous row label, current row label}
    logic [2*LB-1:0] mem [MAX_WIDTH];

    // write side, halves enabled separately
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cur) begin
            mem[i_cmd.wr_addr[AW-1:0]][LB-1:0] <= i_cmd.cur_data;
        end
        if (i_cmd.wr_prev) begin
            mem[i_cmd.wr_addr[AW-1:0]][2*LB-1:LB] <= i_cmd.prev_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            o_rdata <= mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

endmodule
`default_nettype wire
